>>> design/timer_prescaler_compare_select_unit_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the timer prescaler compare select unit
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_COMPARE_SELECT_UNIT_DEFINES_SVH
`define TIMER_PRESCALER_COMPARE_SELECT_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpcs assertion failed");

// implication a fixed number of cycles later
`define TPCS_ASSERT_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("tpcs latency assertion failed");

`endif

>>> design/tpcs_pkg.sv
// ----------------------------------------------------------------------------
// tpcs_pkg
// widths, prescaler table and pipeline types for the prescaler select unit
// ----------------------------------------------------------------------------
package tpcs_pkg;

  localparam int FREQ_W    = 32;
  localparam int CLK_W     = 27;
  localparam int CMP_W     = 8;
  localparam int SEL_W     = 3;
  localparam int NUM_PRESC = 7;
  localparam int C256_W    = CLK_W + 8;
  localparam int NUM_W     = C256_W + 1;
  localparam int PF_W      = FREQ_W + 10;
  localparam int DEN_W     = PF_W + 1;
  localparam int FIT_W     = PF_W + 8;
  localparam int DIV_W     = DEN_W + CMP_W - 1;

  localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(16000000);

  typedef logic [3:0] shift_t;

  // log2 of prescalers 1, 8, 32, 64, 128, 256, 1024
  function automatic shift_t presc_shift(input logic [SEL_W-1:0] idx);
    shift_t s;
    unique case (idx)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [SEL_W-1:0] sel;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [CMP_W-1:0] quo;
  } div_t;

endpackage

>>> design/tpcs_select.sv
// ----------------------------------------------------------------------------
// tpcs_select
// fit test over all prescalers, first fit wins; sets up the rounding division
// ----------------------------------------------------------------------------
module tpcs_select import tpcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FREQ_W-1:0] f,
  input  logic [CLK_W-1:0]  clock_hz,
  output div_t              out
);

  logic [C256_W-1:0] c256;
  logic [PF_W-1:0]   pf;
  logic [PF_W-1:0]   pf_sel;
  logic [SEL_W-1:0]  sel;
  logic              hit;
  div_t              out_next;

  always_comb begin
    c256   = {clock_hz, 8'd0};
    pf_sel = '0;
    sel    = '0;
    hit    = 1'b0;
    // walk down so the smallest fitting prescaler is the one left
    for (int i = NUM_PRESC - 1; i >= 0; i--) begin
      pf = PF_W'(f) << presc_shift(SEL_W'(i));
      if (f != '0 && pf <= PF_W'(c256) && FIT_W'(c256) <= (FIT_W'(pf) << 8)) begin
        pf_sel = pf;
        sel    = SEL_W'(i + 1);
        hit    = 1'b1;
      end
    end
    out_next.valid = in_valid;
    out_next.hit   = hit;
    out_next.sel   = sel;
    // round half up: (2*256c - pf) / (2*pf)
    out_next.rem   = {c256, 1'b0} - NUM_W'(pf_sel);
    out_next.den   = {pf_sel, 1'b0};
    out_next.quo   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= out_next.valid;
    end
    out.hit <= out_next.hit;
    out.sel <= out_next.sel;
    out.rem <= out_next.rem;
    out.den <= out_next.den;
    out.quo <= out_next.quo;
  end

endmodule

>>> design/tpcs_div_stage.sv
// ----------------------------------------------------------------------------
// tpcs_div_stage
// one restoring division step, resolves one quotient bit
// ----------------------------------------------------------------------------
module tpcs_div_stage import tpcs_pkg::*; #(
  parameter int BIT = 7
) (
  input  logic clk,
  input  logic rst,
  input  div_t in,
  output div_t out
);

  logic [DIV_W-1:0] trial;
  logic             ge;
  div_t             out_next;

  always_comb begin
    trial    = DIV_W'(in.den) << BIT;
    ge       = DIV_W'(in.rem) >= trial;
    out_next = in;
    if (ge) begin
      out_next.rem = in.rem - NUM_W'(trial);
    end
    out_next.quo[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= out_next.valid;
    end
    out.hit <= out_next.hit;
    out.sel <= out_next.sel;
    out.rem <= out_next.rem;
    out.den <= out_next.den;
    out.quo <= out_next.quo;
  end

endmodule

>>> design/timer_prescaler_compare_select_unit.sv
// ----------------------------------------------------------------------------
// timer_prescaler_compare_select_unit
// picks the first fitting timer prescaler and its rounded compare value
// ----------------------------------------------------------------------------
//  channel   signals                          transfer when
//  request   start, busy, freq_q8             start & !busy
//  result    done, compare_value, ...found    done (one cycle, no back-pressure)
//  config    cfg_valid, cfg_ready, cfg_data   cfg_valid & cfg_ready
//
//  one request per cycle while busy is low, result registered through the stages below
//  stages: input register, prescaler fit stage, eight restoring division steps
//  busy is high only during reset; results cannot be stalled
//  reset clears the pipeline valids and loads clock_hz with 16 MHz
// ----------------------------------------------------------------------------
module timer_prescaler_compare_select_unit import tpcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FREQ_W-1:0] freq_q8,
  output logic              done,
  output logic [CMP_W-1:0]  compare_value,
  output logic [SEL_W-1:0]  clock_select,
  output logic              found,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data
);

  logic [CLK_W-1:0]  clock_hz;
  logic              in_valid;
  logic [FREQ_W-1:0] f;
  div_t              pipe [CMP_W+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clock_hz <= cfg_data;
      end
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    f <= freq_q8;
  end

  tpcs_select u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .f        (f),
    .clock_hz (clock_hz),
    .out      (pipe[0])
  );

  for (genvar k = 0; k < CMP_W; k++) begin : g_div
    tpcs_div_stage #(.BIT(CMP_W - 1 - k)) u_div (
      .clk (clk),
      .rst (rst),
      .in  (pipe[k]),
      .out (pipe[k+1])
    );
  end

  assign done          = pipe[CMP_W].valid;
  assign found         = pipe[CMP_W].hit;
  assign compare_value = pipe[CMP_W].hit ? pipe[CMP_W].quo : '0;
  assign clock_select  = pipe[CMP_W].hit ? pipe[CMP_W].sel : '0;

endmodule

>>> design/tpcs_checker.sv
// ----------------------------------------------------------------------------
// tpcs_checker
// port-level checks on the prescaler select unit
// ----------------------------------------------------------------------------
`include "timer_prescaler_compare_select_unit_defines.svh"

module tpcs_checker import tpcs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [FREQ_W-1:0] freq_q8,
  input logic              done,
  input logic [CMP_W-1:0]  compare_value,
  input logic [SEL_W-1:0]  clock_select,
  input logic              found
);

  `TPCS_ASSERT_DLY(a_latency, start && !busy, 10, done)
  `TPCS_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 10))
  `TPCS_ASSERT_IMP(a_miss_zero, done && !found, compare_value == '0 && clock_select == '0)
  `TPCS_ASSERT_IMP(a_hit_code, done && found, clock_select != '0)
  `TPCS_ASSERT_IMP(a_zero_freq, start && !busy && freq_q8 == '0, ##10 (done && !found))

endmodule

bind timer_prescaler_compare_select_unit tpcs_checker u_tpcs_checker (.*);

>>> test/timer_prescaler_compare_select_unit_tb.sv
// ----------------------------------------------------------------------------
// timer_prescaler_compare_select_unit_tb
// drives wanted tick frequencies through the prescaler select unit under
// several core clock settings and checks every compare value, clock select
// and found flag against an exact rational predictor or typed expectations, in request order
// ----------------------------------------------------------------------------
module timer_prescaler_compare_select_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpcs_pkg::*;

  localparam logic [SEL_W-1:0] SEL_NONE    = 3'd0;
  localparam logic [SEL_W-1:0] SEL_DIV1    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_DIV8    = 3'd2;
  localparam logic [SEL_W-1:0] SEL_DIV32   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DIV64   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_DIV128  = 3'd5;
  localparam logic [SEL_W-1:0] SEL_DIV256  = 3'd6;
  localparam logic [SEL_W-1:0] SEL_DIV1024 = 3'd7;
  localparam int PIPE_CYCLES = 14;

  typedef struct packed {
    logic [CMP_W-1:0] cmp;
    logic [SEL_W-1:0] sel;
    logic             hit;
  } timer_setting_t;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    bit                typed;
    timer_setting_t    want;
  } freq_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FREQ_W-1:0] freq_q8 = '0;
  logic              done;
  logic [CMP_W-1:0]  compare_value;
  logic [SEL_W-1:0]  clock_select;
  logic              found;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CLK_W-1:0]  cfg_data = '0;

  logic [CLK_W-1:0]  core_clock_hz;
  timer_setting_t    pending_settings[$];
  int                mismatches = 0;
  bit                allow_idle = 1'b1;

  longint unsigned   presc_ratio[7] = '{1, 8, 32, 64, 128, 256, 1024};

  timer_prescaler_compare_select_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .freq_q8(freq_q8),
    .done(done), .compare_value(compare_value), .clock_select(clock_select),
    .found(found), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // first prescaler whose ideal compare value lies in 0..255
  function automatic timer_setting_t pick_prescaler(logic [FREQ_W-1:0] f,
                                                    logic [CLK_W-1:0] c);
    timer_setting_t  res;
    longint unsigned c256;
    longint unsigned pf;
    longint unsigned q;
    res = '0;
    c256 = longint'(c) << 8;
    if (f != 0) begin
      for (int i = 0; i < 7; i++) begin
        pf = presc_ratio[i] * longint'(f);
        if (pf <= c256 && c256 <= (pf << 8)) begin
          q = ((c256 << 1) - pf) / (pf << 1);
          res.cmp = (q > 255) ? 8'd255 : q[CMP_W-1:0];
          res.sel = SEL_W'(i + 1);
          res.hit = 1'b1;
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    timer_setting_t w;
    if (!rst && done) begin
      if (pending_settings.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = pending_settings.pop_front();
        if (compare_value !== w.cmp) report("compare_value", compare_value, w.cmp);
        if (clock_select !== w.sel) report("clock_select", clock_select, w.sel);
        if (found !== w.hit) report("found", found, w.hit);
      end
    end
  end

  task automatic send_freq(logic [FREQ_W-1:0] f, bit typed, timer_setting_t want);
    int gap;
    start <= 1'b1;
    freq_q8 <= f;
    do @(posedge clk); while (busy);
    pending_settings.push_back(typed ? want : pick_prescaler(f, core_clock_hz));
    gap = 0;
    if (allow_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_core_clock(logic [CLK_W-1:0] v);
    start <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    core_clock_hz = v;
  endtask

  // mostly frequencies aimed near a chosen prescaler and compare value
  function automatic logic [FREQ_W-1:0] random_freq();
    longint unsigned t;
    int idx;
    int r;
    if ($urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, 6);
      r = $urandom_range(0, 255);
      t = (longint'(core_clock_hz) << 8) / (presc_ratio[idx] * (r + 1));
      t = t + $urandom_range(0, 2);
      if (t > 0) t = t - 1;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      return t[FREQ_W-1:0];
    end
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) send_freq(random_freq(), 1'b0, '0);
  endtask

  freq_row_t directed[] = '{
    '{32'd0,          1'b1, '{8'd0,   SEL_NONE,  1'b0}},
    '{32'hFFFF_FFFF,  1'b1, '{8'd0,   SEL_NONE,  1'b0}},
    '{32'd1,          1'b1, '{8'd0,   SEL_NONE,  1'b0}},
    '{32'd4096000000, 1'b1, '{8'd0,   SEL_DIV1,  1'b1}},
    '{32'd256000,     1'b1, '{8'd249, SEL_DIV64, 1'b1}},
    '{32'd16000000,   1'b0, '0},
    '{32'd4000000,    1'b0, '0},
    '{32'd1000000,    1'b0, '0},
    '{32'd100000,     1'b0, '0},
    '{32'd20000,      1'b0, '0},
    '{32'd15625,      1'b0, '0},
    '{32'd15624,      1'b0, '0},
    '{32'd2000000000, 1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0}
  };

  initial begin
    core_clock_hz = CLOCK_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_freq(directed[i].freq, directed[i].typed, directed[i].want);
    random_items(250);
    set_core_clock(CLK_W'(100000000));
    send_freq(32'hFFFF_FFFF, 1'b0, '0);
    random_items(200);
    set_core_clock(CLK_W'(1));
    send_freq(32'd256, 1'b1, '{8'd0, SEL_DIV1, 1'b1});
    random_items(100);
    set_core_clock({CLK_W{1'b1}});
    random_items(150);
    set_core_clock('0);
    send_freq(32'd1, 1'b1, '{8'd0, SEL_NONE, 1'b0});
    random_items(50);
    set_core_clock(CLOCK_RESET);
    random_items(100);
    allow_idle = 1'b0;
    random_items(100);
    start <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/tpcs_pkg.sv
design/tpcs_select.sv
design/tpcs_div_stage.sv
design/timer_prescaler_compare_select_unit.sv
design/tpcs_checker.sv
test/timer_prescaler_compare_select_unit_tb.sv
